// File: src/qte_pkg.sv
// Shared constants, types and elaboration-time arctangent table for the quaternion converter.
`timescale 1ns / 1ps

package qte_pkg;

	localparam int ACC_FRAC      = 60;  // fraction bits of the angle accumulator
	localparam int NORM_BITS     = 30;  // normalized magnitudes lie in [2^29, 2^30)
	localparam int NORM_R_STAGES = 6;   // right shifts by 32, 16, 8, 4, 2, 1
	localparam int NORM_L_STAGES = 5;   // left shifts by 16, 8, 4, 2, 1
	localparam int CORDIC_W      = 34;  // signed width of the rotating vector
	localparam int ZACC_W        = 64;  // signed width of the angle accumulator
	localparam int RAD_W         = 61;  // radicand 1 - s^2 in Q60
	localparam int ROOT_W        = 31;  // floor square root of the radicand
	localparam int SQRT_STEPS    = 31;  // one result bit per stage

	typedef struct packed {
		logic roll_sneg;
		logic roll_cneg;
		logic yaw_sneg;
		logic yaw_cneg;
		logic pitch_neg;
		logic pitch_clamp;
	} quad_flags_t;

	// restoring long division, used only while building constants
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(1/n) in Q60 by its alternating series, each term truncated
	function automatic logic signed [63:0] arctan_recip(input logic [63:0] n);
		logic [63:0] term;
		logic [63:0] n2;
		logic [63:0] k;
		logic [63:0] q;
		logic signed [63:0] sum;
		term = udiv64(64'd1 << ACC_FRAC, n);
		n2   = n * n;
		k    = '0;
		sum  = '0;
		while (term != '0) begin
			q = udiv64(term, (k << 1) + 64'd1);
			if (!k[0]) begin
				sum = sum + $signed(q);
			end else begin
				sum = sum - $signed(q);
			end
			term = udiv64(term, n2);
			k    = k + 64'd1;
		end
		return sum;
	endfunction

	// CORDIC angle table entry: atan(2^-i) in Q60
	function automatic logic signed [63:0] atan_q60(input int i);
		logic signed [63:0] v;
		if (i == 0) begin
			v = arctan_recip(64'd2) + arctan_recip(64'd3);
		end else begin
			v = arctan_recip(64'd1 << i);
		end
		return v;
	endfunction

endpackage

// File: src/quaternion_to_euler_angles.sv
// Top level: unit quaternion in, roll, pitch and yaw angles out, fully pipelined.
`timescale 1ns / 1ps

//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | quat_x, quat_y, quat_z, quat_w (Q1.QFB)
//  result   | done (1-cycle)     | roll_angle, pitch_angle, yaw_angle (Q.AFB)
//
//  One quaternion is taken every cycle; busy is never raised.
//  The pitch path runs through products, sums, magnitude prep, the squarer,
//  the radicand, a 31-stage square root, then 11 normalize stages,
//  ANGLE_FRAC_BITS + 4 CORDIC stages, clamp, round, and the final quadrant
//  stage. Roll and yaw ride a shift line to match.
//  Reset clears only the valid chain; payload registers load freely.
//  The receiver cannot stall, so done pulses exactly once per transfer.

module quaternion_to_euler_angles
	import qte_pkg::*;
#(
	parameter int QUAT_FRAC_BITS  = 15,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [QUAT_FRAC_BITS:0]    quat_x,
	input  logic signed [QUAT_FRAC_BITS:0]    quat_y,
	input  logic signed [QUAT_FRAC_BITS:0]    quat_z,
	input  logic signed [QUAT_FRAC_BITS:0]    quat_w,
	output logic                              done,
	output logic signed [ANGLE_FRAC_BITS+2:0] roll_angle,
	output logic signed [ANGLE_FRAC_BITS+1:0] pitch_angle,
	output logic signed [ANGLE_FRAC_BITS+2:0] yaw_angle
);

	localparam int PRODW     = 2 * QUAT_FRAC_BITS + 2;  // one product
	localparam int SUMW      = 2 * QUAT_FRAC_BITS + 4;  // doubled sums
	localparam int TWOQ      = 2 * QUAT_FRAC_BITS;
	localparam int WIDEW     = ANGLE_FRAC_BITS + 3;
	localparam int PITW      = ANGLE_FRAC_BITS + 2;
	localparam int AW        = ANGLE_FRAC_BITS + 1;
	localparam int ATAN_LAT  = NORM_R_STAGES + NORM_L_STAGES + ANGLE_FRAC_BITS + 4 + 2;
	localparam int PITCH_PRE = 2 + SQRT_STEPS;          // squarer, radicand, root
	localparam int TOTAL     = 3 + PITCH_PRE + ATAN_LAT + 1;

	localparam logic signed [SUMW-1:0] ONE_Q = SUMW'(1) <<< TWOQ;
	localparam logic [63:0] TAB0     = atan_q60(0);
	localparam logic [63:0] HALF_RND = 64'd1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS);
	localparam logic [63:0] PI_FULL  = ((TAB0 << 2) + HALF_RND) >> (ACC_FRAC - ANGLE_FRAC_BITS);
	localparam logic [63:0] HP_FULL  = ((TAB0 << 1) + HALF_RND) >> (ACC_FRAC - ANGLE_FRAC_BITS);
	localparam logic signed [WIDEW-1:0] PI_OUT   = WIDEW'(PI_FULL);
	localparam logic signed [PITW-1:0]  HALF_OUT = PITW'(HP_FULL);

	// valid chain, one bit per pipeline register stage
	logic valid_sn [TOTAL];

	// stage 1: products
	logic signed [PRODW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PRODW-1:0] wy_s1, zx_s1, wz_s1, xy_s1;

	// stage 2: doubled sums
	logic signed [SUMW-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;

	// stage 3: magnitudes and quadrant flags
	logic [SUMW-1:0] sr_mag, cr_mag, sy_mag, cy_mag, sp_mag;
	logic [SUMW-1:0] sr_mag_s3, cr_mag_s3, sy_mag_s3, cy_mag_s3;
	logic [NORM_BITS-1:0] u30, u30_s3;
	quad_flags_t flags_s3;

	// pitch radicand
	logic [2*NORM_BITS-1:0] sq_s4;
	logic [RAD_W-1:0]       rad_s5;
	logic [ROOT_W-1:0]      root;
	logic [NORM_BITS-1:0]   u30_d;

	logic [AW-1:0] roll_a, yaw_a, pitch_a, roll_a_d, yaw_a_d;
	quad_flags_t   flags_d;
	logic [$bits(quad_flags_t)-1:0] flags_vec_d;

	logic signed [WIDEW-1:0] roll_q, yaw_q;
	logic signed [PITW-1:0]  pitch_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TOTAL; k++) begin
				valid_sn[k] <= 1'b0;
			end
		end else begin
			valid_sn[0] <= start && !busy;
			for (int k = 1; k < TOTAL; k++) begin
				valid_sn[k] <= valid_sn[k-1];
			end
		end
	end

	assign done = valid_sn[TOTAL-1];

	// nine products, exact
	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
		wy_s1 <= quat_w * quat_y;
		zx_s1 <= quat_z * quat_x;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
	end

	// sine and cosine terms of the three angles
	always_ff @(posedge clk) begin
		sr_s2 <= (SUMW'(wx_s1) + SUMW'(yz_s1)) <<< 1;
		cr_s2 <= ONE_Q - ((SUMW'(xx_s1) + SUMW'(yy_s1)) <<< 1);
		sp_s2 <= (SUMW'(wy_s1) - SUMW'(zx_s1)) <<< 1;
		sy_s2 <= (SUMW'(wz_s1) + SUMW'(xy_s1)) <<< 1;
		cy_s2 <= ONE_Q - ((SUMW'(yy_s1) + SUMW'(zz_s1)) <<< 1);
	end

	assign sr_mag = sr_s2[SUMW-1] ? SUMW'(-sr_s2) : SUMW'(sr_s2);
	assign cr_mag = cr_s2[SUMW-1] ? SUMW'(-cr_s2) : SUMW'(cr_s2);
	assign sy_mag = sy_s2[SUMW-1] ? SUMW'(-sy_s2) : SUMW'(sy_s2);
	assign cy_mag = cy_s2[SUMW-1] ? SUMW'(-cy_s2) : SUMW'(cy_s2);
	assign sp_mag = sp_s2[SUMW-1] ? SUMW'(-sp_s2) : SUMW'(sp_s2);

	// rescale the pitch argument to Q30; only meaningful below one
	if (TWOQ >= NORM_BITS) begin : g_u_down
		assign u30 = NORM_BITS'(sp_mag >> (TWOQ - NORM_BITS));
	end else begin : g_u_up
		assign u30 = NORM_BITS'(sp_mag) << (NORM_BITS - TWOQ);
	end

	always_ff @(posedge clk) begin
		sr_mag_s3            <= sr_mag;
		cr_mag_s3            <= cr_mag;
		sy_mag_s3            <= sy_mag;
		cy_mag_s3            <= cy_mag;
		u30_s3               <= u30;
		flags_s3.roll_sneg   <= sr_s2[SUMW-1];
		flags_s3.roll_cneg   <= cr_s2[SUMW-1];
		flags_s3.yaw_sneg    <= sy_s2[SUMW-1];
		flags_s3.yaw_cneg    <= cy_s2[SUMW-1];
		flags_s3.pitch_neg   <= sp_s2[SUMW-1];
		flags_s3.pitch_clamp <= (sp_mag >> TWOQ) != '0;
	end

	// cosine of pitch: sqrt(1 - s^2) in Q30
	always_ff @(posedge clk) begin
		sq_s4  <= u30_s3 * u30_s3;
		rad_s5 <= (RAD_W'(1) << (2 * NORM_BITS)) - RAD_W'(sq_s4);
	end

	qte_isqrt u_isqrt (
		.clk  (clk),
		.rad  (rad_s5),
		.root (root)
	);

	qte_delay #(.WIDTH(NORM_BITS), .DEPTH(PITCH_PRE)) u_dly_u30 (
		.clk  (clk),
		.din  (u30_s3),
		.dout (u30_d)
	);

	qte_atan #(.IN_W(ROOT_W), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atan_pitch (
		.clk   (clk),
		.ay    (ROOT_W'(u30_d)),
		.ax    (root),
		.angle (pitch_a)
	);

	qte_atan #(.IN_W(SUMW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atan_roll (
		.clk   (clk),
		.ay    (sr_mag_s3),
		.ax    (cr_mag_s3),
		.angle (roll_a)
	);

	qte_atan #(.IN_W(SUMW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atan_yaw (
		.clk   (clk),
		.ay    (sy_mag_s3),
		.ax    (cy_mag_s3),
		.angle (yaw_a)
	);

	// hold roll and yaw until the pitch result catches up
	qte_delay #(.WIDTH(2 * AW), .DEPTH(PITCH_PRE)) u_dly_ry (
		.clk  (clk),
		.din  ({roll_a, yaw_a}),
		.dout ({roll_a_d, yaw_a_d})
	);

	qte_delay #(.WIDTH($bits(quad_flags_t)), .DEPTH(PITCH_PRE + ATAN_LAT)) u_dly_flags (
		.clk  (clk),
		.din  (flags_s3),
		.dout (flags_vec_d)
	);

	assign flags_d = quad_flags_t'(flags_vec_d);

	// fold a first-quadrant angle out to the full circle
	function automatic logic signed [WIDEW-1:0] unfold(input logic [AW-1:0] a,
	                                                   input logic sneg, input logic cneg);
		logic signed [WIDEW-1:0] t;
		t = $signed(WIDEW'(a));
		if (cneg) begin
			t = PI_OUT - t;
		end
		if (sneg) begin
			t = -t;
		end
		return t;
	endfunction

	always_ff @(posedge clk) begin
		roll_q <= unfold(roll_a_d, flags_d.roll_sneg, flags_d.roll_cneg);
		yaw_q  <= unfold(yaw_a_d, flags_d.yaw_sneg, flags_d.yaw_cneg);
		if (flags_d.pitch_clamp) begin
			pitch_q <= flags_d.pitch_neg ? -HALF_OUT : HALF_OUT;
		end else begin
			pitch_q <= flags_d.pitch_neg ? -$signed(PITW'(pitch_a)) : $signed(PITW'(pitch_a));
		end
	end

	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

`ifndef SYNTHESIS
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= HALF_OUT) && (pitch_angle >= -HALF_OUT))
		else $error("pitch outside +-pi/2");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll_angle <= PI_OUT) && (roll_angle >= -PI_OUT))
		else $error("roll outside +-pi");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (yaw_angle <= PI_OUT) && (yaw_angle >= -PI_OUT))
		else $error("yaw outside +-pi");
`endif

endmodule

// File: src/qte_delay.sv
// Fixed-length shift line that carries side data alongside a pipeline.
`timescale 1ns / 1ps

module qte_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		tap_s[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

// File: src/qte_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
`timescale 1ns / 1ps

module qte_isqrt
	import qte_pkg::*;
(
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0] rem_s [SQRT_STEPS];
	logic [RAD_W:0]   res_s [SQRT_STEPS];

	genvar j;
	for (j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [RAD_W-1:0] rem_i;
		logic [RAD_W:0]   res_i;
		logic [RAD_W+1:0] trial;

		if (j == 0) begin : g_first
			assign rem_i = rad;
			assign res_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign res_i = res_s[j-1];
		end

		assign trial = {1'b0, res_i} + {1'b0, BIT};

		always_ff @(posedge clk) begin
			if ({2'b00, rem_i} >= trial) begin
				rem_s[j] <= RAD_W'({2'b00, rem_i} - trial);
				res_s[j] <= (res_i >> 1) + BIT;
			end else begin
				rem_s[j] <= rem_i;
				res_s[j] <= res_i >> 1;
			end
		end
	end

	assign root = res_s[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// File: src/qte_atan.sv
// First-quadrant arctangent: staged normalization, CORDIC vectoring, clamp and rounding.
`timescale 1ns / 1ps

module qte_atan
	import qte_pkg::*;
#(
	parameter int IN_W            = 34,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                     clk,
	input  logic [IN_W-1:0]          ay,
	input  logic [IN_W-1:0]          ax,
	output logic [ANGLE_FRAC_BITS:0] angle
);

	localparam int NW    = (IN_W > NORM_BITS + 1) ? IN_W : NORM_BITS + 1;
	localparam int NSH   = NORM_R_STAGES + NORM_L_STAGES;
	localparam int ITERS = ANGLE_FRAC_BITS + 4;
	localparam logic signed [ZACC_W-1:0] HALF_PI = atan_q60(0) <<< 1;
	localparam logic [ZACC_W-1:0] RND = ZACC_W'(1) << (ACC_FRAC - 1 - ANGLE_FRAC_BITS);

	logic [NW-1:0] nx_s [NSH];
	logic [NW-1:0] ny_s [NSH];
	logic [NW-1:0] nm_s [NSH];
	logic          nz_s [NSH];

	logic signed [CORDIC_W-1:0] cx_s [ITERS];
	logic signed [CORDIC_W-1:0] cy_s [ITERS];
	logic signed [ZACC_W-1:0]   cz_s [ITERS];
	logic                       czero_s [ITERS];

	logic [ZACC_W-1:0] zc_s;
	logic [ZACC_W-1:0] rnd_sum;
	logic [ANGLE_FRAC_BITS:0] angle_s;

	// normalize the larger magnitude into [2^29, 2^30), truncating right shifts
	genvar j;
	for (j = 0; j < NSH; j++) begin : g_norm
		localparam bit RIGHT = (j < NORM_R_STAGES);
		localparam int SH = RIGHT ? (1 << (NORM_R_STAGES - 1 - j))
		                          : (1 << (NORM_L_STAGES - 1 - (j - NORM_R_STAGES)));
		logic [NW-1:0] x_i, y_i, m_i;
		logic          z_i, shift_en;

		if (j == 0) begin : g_first
			assign x_i = NW'(ax);
			assign y_i = NW'(ay);
			assign m_i = (ax > ay) ? NW'(ax) : NW'(ay);
			assign z_i = (ax == '0) && (ay == '0);
		end else begin : g_next
			assign x_i = nx_s[j-1];
			assign y_i = ny_s[j-1];
			assign m_i = nm_s[j-1];
			assign z_i = nz_s[j-1];
		end

		assign shift_en = RIGHT ? ((m_i >> (NORM_BITS - 1 + SH)) != '0)
		                        : ((m_i >> (NORM_BITS - SH)) == '0);

		always_ff @(posedge clk) begin
			nz_s[j] <= z_i;
			if (!shift_en) begin
				nx_s[j] <= x_i;
				ny_s[j] <= y_i;
				nm_s[j] <= m_i;
			end else if (RIGHT) begin
				nx_s[j] <= x_i >> SH;
				ny_s[j] <= y_i >> SH;
				nm_s[j] <= m_i >> SH;
			end else begin
				nx_s[j] <= x_i << SH;
				ny_s[j] <= y_i << SH;
				nm_s[j] <= m_i << SH;
			end
		end
	end

	// vectoring: drive y toward zero, accumulate the angle
	genvar i;
	for (i = 0; i < ITERS; i++) begin : g_cordic
		localparam logic signed [ZACC_W-1:0] ANG = atan_q60(i);
		logic signed [CORDIC_W-1:0] x_i, y_i, xs, ys;
		logic signed [ZACC_W-1:0]   z_i;
		logic                       zero_i;

		if (i == 0) begin : g_first
			assign x_i    = $signed({{(CORDIC_W-NORM_BITS){1'b0}}, nx_s[NSH-1][NORM_BITS-1:0]});
			assign y_i    = $signed({{(CORDIC_W-NORM_BITS){1'b0}}, ny_s[NSH-1][NORM_BITS-1:0]});
			assign z_i    = '0;
			assign zero_i = nz_s[NSH-1];
		end else begin : g_next
			assign x_i    = cx_s[i-1];
			assign y_i    = cy_s[i-1];
			assign z_i    = cz_s[i-1];
			assign zero_i = czero_s[i-1];
		end

		assign xs = x_i >>> i;
		assign ys = y_i >>> i;

		always_ff @(posedge clk) begin
			czero_s[i] <= zero_i;
			if (!y_i[CORDIC_W-1]) begin
				cx_s[i] <= x_i + ys;
				cy_s[i] <= y_i - xs;
				cz_s[i] <= z_i + ANG;
			end else begin
				cx_s[i] <= x_i - ys;
				cy_s[i] <= y_i + xs;
				cz_s[i] <= z_i - ANG;
			end
		end
	end

	// clamp to [0, pi/2], then round half up
	always_ff @(posedge clk) begin
		if (czero_s[ITERS-1] || cz_s[ITERS-1][ZACC_W-1]) begin
			zc_s <= '0;
		end else if (cz_s[ITERS-1] > HALF_PI) begin
			zc_s <= HALF_PI;
		end else begin
			zc_s <= cz_s[ITERS-1];
		end
	end

	assign rnd_sum = zc_s + RND;

	always_ff @(posedge clk) begin
		angle_s <= rnd_sum[ACC_FRAC-ANGLE_FRAC_BITS +: ANGLE_FRAC_BITS+1];
	end

	assign angle = angle_s;

endmodule

// File: dv/quaternion_to_euler_angles_checker.sv
// Result checker for the quaternion to Euler angle converter: predicts and compares.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               done,
	input  logic signed [15:0] roll_angle,
	input  logic signed [14:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output int                 errors,
	output int                 pending
);
	localparam int QFB   = 15;
	localparam int AFB   = 13;
	localparam int STEPS = AFB + 4;
	localparam int ACC   = qte_pkg::ACC_FRAC;

	typedef struct packed {
		logic [15:0] roll;
		logic [14:0] pitch;
		logic [15:0] yaw;
	} euler_t;

	euler_t euler_q[$];
	longint atan_lut[32];

	// atan(1/n) in Q60 by its alternating series, each term truncated
	function automatic longint atan_inv(longint unsigned n);
		longint unsigned term, n2, k;
		longint sum;
		term = (64'd1 << ACC) / n;
		n2   = n * n;
		k    = 0;
		sum  = 0;
		while (term != 0) begin
			if (k[0]) sum -= longint'(term / (2 * k + 1));
			else sum += longint'(term / (2 * k + 1));
			term = term / n2;
			k++;
		end
		return sum;
	endfunction

	initial begin
		atan_lut[0] = atan_inv(2) + atan_inv(3);
		for (int i = 1; i < 32; i++) atan_lut[i] = atan_inv(64'd1 << i);
	end

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint round_angle(longint unsigned q);
		return longint'((q + (64'd1 << (ACC - 1 - AFB))) >> (ACC - AFB));
	endfunction

	// first-quadrant arctangent of ay/ax in Q60, clamped to [0, pi/2]
	function automatic longint unsigned octant_angle(longint unsigned ay, longint unsigned ax);
		longint unsigned m;
		longint vx, vy, xs, ys, acc;
		m   = ax > ay ? ax : ay;
		acc = 0;
		if (m == 0) return 0;
		while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
		while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
		vx = ax;
		vy = ay;
		for (int i = 0; i < STEPS; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx += ys; vy -= xs; acc += atan_lut[i];
			end else begin
				vx -= ys; vy += xs; acc -= atan_lut[i];
			end
		end
		if (acc < 0) acc = 0;
		if (acc > 2 * atan_lut[0]) acc = 2 * atan_lut[0];
		return acc;
	endfunction

	function automatic longint full_atan2(longint s, longint c);
		longint a;
		a = round_angle(octant_angle(abs64(s), abs64(c)));
		if (c < 0) a = round_angle(4 * atan_lut[0]) - a;
		return s < 0 ? -a : a;
	endfunction

	function automatic longint clamped_asin(longint s);
		longint unsigned u, r, root, b;
		longint a;
		u = abs64(s);
		if (u >= (64'd1 << (2 * QFB))) begin
			a = round_angle(2 * atan_lut[0]);
			return s < 0 ? -a : a;
		end
		u    = u << (30 - 2 * QFB);
		r    = (64'd1 << 60) - u * u;
		root = 0;
		b    = 64'd1 << 62;
		while (b > r) b >>= 2;
		while (b != 0) begin
			if (r >= root + b) begin
				r -= root + b;
				root = (root >> 1) + b;
			end else root >>= 1;
			b >>= 2;
		end
		a = round_angle(octant_angle(u, root));
		return s < 0 ? -a : a;
	endfunction

	function automatic euler_t predict_euler(longint x, longint y, longint z, longint w);
		longint one;
		euler_t e;
		longint r, p, yw;
		one = longint'(1) << (2 * QFB);
		r   = full_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y));
		p   = clamped_asin(2 * (w * y - z * x));
		yw  = full_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z));
		e.roll  = r[15:0];
		e.pitch = p[14:0];
		e.yaw   = yw[15:0];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		euler_t exp_e;
		int     nerr;
		nerr = 0;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (euler_q.size() == 0) begin
					$error("result with no transfer outstanding");
					nerr++;
				end else begin
					exp_e = euler_q.pop_front();
					if (roll_angle !== exp_e.roll) begin
						$error("roll_angle exp %0d got %0d", $signed(exp_e.roll), roll_angle);
						nerr++;
					end
					if (pitch_angle !== exp_e.pitch) begin
						$error("pitch_angle exp %0d got %0d", $signed(exp_e.pitch), pitch_angle);
						nerr++;
					end
					if (yaw_angle !== exp_e.yaw) begin
						$error("yaw_angle exp %0d got %0d", $signed(exp_e.yaw), yaw_angle);
						nerr++;
					end
				end
			end
			if (start && !busy)
				euler_q.push_back(predict_euler(quat_x, quat_y, quat_z, quat_w));
			pending <= euler_q.size();
			errors  <= errors + nerr;
		end
	end
endmodule

// File: dv/quaternion_to_euler_angles_tb.sv
// Testbench top: drives quaternion transfers and reports the verdict.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic               done;
	logic signed [15:0] roll_angle, yaw_angle;
	logic signed [14:0] pitch_angle;
	int                 errors, pending;

	always #5 clk = ~clk;

	quaternion_to_euler_angles dut (.*);
	quaternion_to_euler_angles_checker chk (.*);

	// hold the item on the ports until the block takes it; start stays high
	// so back-to-back transfers keep the pipeline full
	task automatic send_quat(input logic [15:0] x, y, z, w);
		start  <= 1'b1;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		quat_w <= w;
		@(posedge clk iff !busy);
	endtask

	// drop start for a random idle burst
	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 16)) @(posedge clk);
	endtask

	// random unit quaternion in Q1.15, optionally pushed toward gimbal lock
	task automatic send_unit(input bit near_lock);
		real v[4];
		real n;
		for (int i = 0; i < 4; i++) v[i] = real'(int'($urandom_range(0, 2000)) - 1000);
		if (near_lock) begin
			v[1] = v[3] + real'(int'($urandom_range(0, 8)) - 4);
			v[0] = v[0] / 64.0;
			v[2] = v[2] / 64.0;
		end
		n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
		if (n == 0.0) begin
			v[3] = 1.0;
			n = 1.0;
		end
		send_quat(16'(int'(v[0] / n * 32767.0)), 16'(int'(v[1] / n * 32767.0)),
			16'(int'(v[2] / n * 32767.0)), 16'(int'(v[3] / n * 32767.0)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, zero, axis rotations, extremes, gimbal lock
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);     // sine zero, cosine negative
		send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
		send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
		send_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
		send_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170);
		send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);  // just below lock
		send_quat(16'sd0, 16'sd23171, 16'sd0, 16'sd23171);  // pitch clamps high
		send_quat(16'sd0, -16'sd23171, 16'sd0, 16'sd23171); // pitch clamps low
		send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		send_quat(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
		send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
		send_quat(16'sd0, 16'sd0, -16'sd23170, -16'sd23170);
		send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd1);

		// pause until the pipeline has drained
		start <= 1'b0;
		while (pending != 0 || chk.euler_q.size() != 0) @(posedge clk);

		// random: mostly unit quaternions, some near lock, some raw noise
		for (int n = 0; n < 400; n++) begin
			if (n < 320 && $urandom_range(0, 5) == 0) idle_burst();
			case ($urandom_range(0, 9))
				0, 1:    send_quat(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				2:       send_unit(1'b1);
				default: send_unit(1'b0);
			endcase
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
